/* sv/spd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and codes for the shortest path block.
// No dependencies; every other file uses it.
package spd_pkg;

  localparam int DEF_MAX_NODES   = 64;
  localparam int DEF_WEIGHT_BITS = 20;
  localparam int DEF_DIST_BITS   = 32;

  localparam int NODE_W   = 7;
  localparam int CMD_W    = 2;
  localparam int WEIGHT_W = 20;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

endpackage

/* sv/spd_if.sv */
`timescale 1ns / 1ps
// Valid/ready channels for edge, solve and clear commands and for path results.
// Depends on spd_pkg.
interface spd_item_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::CMD_W-1:0]    command;
  logic [spd_pkg::NODE_W-1:0]   first_node;
  logic [spd_pkg::NODE_W-1:0]   second_node;
  logic [spd_pkg::WEIGHT_W-1:0] edge_weight;
  modport source (output valid, command, first_node, second_node, edge_weight, input ready);
  modport sink   (input valid, command, first_node, second_node, edge_weight, output ready);
endinterface

interface spd_result_if;
  logic                       valid;
  logic                       ready;
  logic [spd_pkg::NODE_W-1:0] path_node;
  logic                       no_path;
  logic                       last;
  modport source (output valid, path_node, no_path, last, input ready);
  modport sink   (input valid, path_node, no_path, last, output ready);
endinterface

/* sv/shortest_path_dijkstra_top.sv */
`timescale 1ns / 1ps
// Shortest path from node 1 to node node_count over a loaded edge store.
// Depends on spd_pkg and the channel interfaces in spd_if.sv.
//
// Edges load through read, compare and two mirrored writes to the edge
// memory, which has one write port. A solve is a plain O(n^2) Dijkstra run
// with one saturating adder: each extraction scan and each relaxation pass
// steps through the nodes with an address state, then a registered read.
// The path is then traced back through the predecessors onto a stack and
// popped and emitted node by node. After reset, and on every clear command,
// the edge memory is swept one entry a cycle over all 2^(2*clog2(MAX_NODES))
// entries (4096 at 64 nodes); no item is taken meanwhile, but node_count
// writes are. One item is in work at a time.
module shortest_path_dijkstra_top #(
  parameter int MAX_NODES   = spd_pkg::DEF_MAX_NODES,
  parameter int WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS,
  parameter int DIST_BITS   = spd_pkg::DEF_DIST_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  spd_item_if.sink                   item,
  spd_result_if.source               result,
  input  logic                       cfg_we,
  input  logic [spd_pkg::NODE_W-1:0] cfg_wdata
);
  import spd_pkg::*;

  localparam int NB    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NB;
  localparam int EDEP  = 1 << AW;
  localparam int CMPW  = (NB + 1 > NODE_W) ? NB + 1 : NODE_W;
  localparam int SW    = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic [AW-1:0] ALAST = AW'(EDEP - 1);
  localparam logic [DIST_BITS-1:0] DMAX = '1;

  typedef enum logic [13:0] {
    S_CLR     = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_ADD_RD  = 14'b00000000000100,
    S_ADD_CHK = 14'b00000000001000,
    S_ADD_WR2 = 14'b00000000010000,
    S_SCAN_A  = 14'b00000000100000,
    S_SCAN_D  = 14'b00000001000000,
    S_RLX_A   = 14'b00000010000000,
    S_RLX_D   = 14'b00000100000000,
    S_TRC_A   = 14'b00001000000000,
    S_TRC_D   = 14'b00010000000000,
    S_POP_A   = 14'b00100000000000,
    S_POP_D   = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  state_t state;

  logic [NODE_W-1:0]      node_count;
  logic [CMPW-1:0]        n_eff;
  logic [NB-1:0]          nlast;

  // memories
  logic [WEIGHT_BITS:0]   edge_mem  [EDEP];
  logic [DIST_BITS-1:0]   dist_mem  [MAX_NODES];
  logic [NB-1:0]          pred_mem  [MAX_NODES];
  logic [NB-1:0]          stack_mem [MAX_NODES];
  logic [WEIGHT_BITS:0]   edge_rd;
  logic [DIST_BITS-1:0]   dist_rd;
  logic [NB-1:0]          pred_rd;
  logic [NB-1:0]          stack_rd;

  logic                   edge_we, dist_we, stack_we;
  logic [AW-1:0]          edge_waddr, edge_raddr;
  logic [WEIGHT_BITS:0]   edge_wdata;
  logic [NB-1:0]          dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0]   dist_wdata;

  // working registers
  logic [AW-1:0]          clr_addr;
  logic [NB-1:0]          ei, ej;
  logic [WEIGHT_BITS-1:0] ew;
  logic [NB-1:0]          idx;
  logic [NB-1:0]          vsel;
  logic [DIST_BITS-1:0]   dbest;
  logic                   found;
  logic [MAX_NODES-1:0]   reached, visited;
  logic [NB-1:0]          cur;
  logic [NB:0]            depth;

  logic [NODE_W-1:0]      out_node;
  logic                   out_no_path, out_last, out_valid;

  logic                   take;
  logic [CMPW-1:0]        a_ext, b_ext;
  logic                   ends_ok;
  logic [WEIGHT_BITS+WEIGHT_W-1:0] w_ext;
  logic [WEIGHT_BITS-1:0] w_in;
  logic [SW-1:0]          sum;
  logic [DIST_BITS-1:0]   nd;
  logic                   relax_hit, scan_hit;
  logic [NB+NODE_W:0]     node_wide;

  assign item.ready    = (state == S_IDLE);
  assign take          = item.valid && item.ready;
  assign result.valid     = out_valid;
  assign result.path_node = out_node;
  assign result.no_path   = out_no_path;
  assign result.last      = out_last;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CMPW'(1);
    end else if (CMPW'(node_count) > CMPW'(MAX_NODES)) begin
      n_eff = CMPW'(MAX_NODES);
    end else begin
      n_eff = CMPW'(node_count);
    end
  end
  assign nlast = NB'(n_eff - CMPW'(1));

  assign a_ext   = CMPW'(item.first_node);
  assign b_ext   = CMPW'(item.second_node);
  assign ends_ok = (a_ext != '0) && (a_ext <= n_eff) && (b_ext != '0) && (b_ext <= n_eff);
  assign w_ext   = {{WEIGHT_BITS{1'b0}}, item.edge_weight};
  assign w_in    = w_ext[WEIGHT_BITS-1:0];

  // saturating add, and the relax and scan compares
  assign sum = {{(SW-DIST_BITS){1'b0}}, dbest} +
               {{(SW-WEIGHT_BITS){1'b0}}, edge_rd[WEIGHT_BITS-1:0]};
  assign nd  = (sum[SW-1:DIST_BITS] != '0) ? DMAX : sum[DIST_BITS-1:0];
  assign relax_hit = edge_rd[WEIGHT_BITS] && !visited[idx] && (!reached[idx] || nd < dist_rd);
  assign scan_hit  = reached[idx] && !visited[idx] && (!found || dist_rd < dbest);

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = clr_addr;
    edge_wdata = '0;
    edge_raddr = {ei, ej};
    case (state)
      S_CLR: begin
        edge_we = 1'b1;
      end
      S_ADD_CHK: begin
        edge_we    = !edge_rd[WEIGHT_BITS] || (ew < edge_rd[WEIGHT_BITS-1:0]);
        edge_waddr = {ei, ej};
        edge_wdata = {1'b1, ew};
      end
      S_ADD_WR2: begin
        edge_we    = 1'b1;
        edge_waddr = {ej, ei};
        edge_wdata = {1'b1, ew};
      end
      S_RLX_A: begin
        edge_raddr = {vsel, idx};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = idx;
    dist_wdata = nd;
    dist_raddr = idx;
    if (take && cmd_t'(item.command) == CMD_SOLVE) begin
      dist_we    = 1'b1;
      dist_waddr = '0;
      dist_wdata = '0;
    end else if (state == S_RLX_D) begin
      dist_we = relax_hit;
    end
  end

  assign stack_we = (state == S_TRC_A);

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd <= edge_mem[edge_raddr];
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    dist_rd <= dist_mem[dist_raddr];
    if (state == S_RLX_D && relax_hit) begin
      pred_mem[idx] <= vsel;
    end
    pred_rd <= pred_mem[cur];
    if (stack_we) begin
      stack_mem[depth[NB-1:0]] <= (cur != '0 && CMPW'(depth) < CMPW'(nlast)) ? cur : '0;
    end
    stack_rd <= stack_mem[NB'(depth - (NB+1)'(1))];
  end

  assign node_wide = (NB+NODE_W+1)'(stack_rd) + (NB+NODE_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      reached   <= '0;
      visited   <= '0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == ALAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            case (cmd_t'(item.command))
              CMD_ADD: begin
                ei <= NB'(a_ext - CMPW'(1));
                ej <= NB'(b_ext - CMPW'(1));
                ew <= w_in;
                if (ends_ok) begin
                  state <= S_ADD_RD;
                end
              end
              CMD_SOLVE: begin
                reached <= MAX_NODES'(1);
                visited <= '0;
                found   <= 1'b0;
                idx     <= '0;
                state   <= S_SCAN_A;
              end
              CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_RD: begin
          state <= S_ADD_CHK;
        end
        S_ADD_CHK: begin
          state <= (!edge_rd[WEIGHT_BITS] || (ew < edge_rd[WEIGHT_BITS-1:0])) ?
                   S_ADD_WR2 : S_IDLE;
        end
        S_ADD_WR2: begin
          state <= S_IDLE;
        end
        S_SCAN_A: begin
          state <= S_SCAN_D;
        end
        S_SCAN_D: begin
          if (scan_hit) begin
            found <= 1'b1;
            dbest <= dist_rd;
            vsel  <= idx;
          end
          if (idx == nlast) begin
            idx <= '0;
            if (found || scan_hit) begin
              visited[scan_hit ? idx : vsel] <= 1'b1;
              state <= S_RLX_A;
            end else begin
              cur   <= nlast;
              depth <= '0;
              if (!reached[nlast]) begin
                out_node    <= '0;
                out_no_path <= 1'b1;
                out_last    <= 1'b1;
                out_valid   <= 1'b1;
                state       <= S_EMIT;
              end else begin
                state <= S_TRC_A;
              end
            end
          end else begin
            idx   <= idx + NB'(1);
            state <= S_SCAN_A;
          end
        end
        S_RLX_A: begin
          state <= S_RLX_D;
        end
        S_RLX_D: begin
          if (relax_hit) begin
            reached[idx] <= 1'b1;
          end
          if (idx == nlast) begin
            idx   <= '0;
            found <= 1'b0;
            state <= S_SCAN_A;
          end else begin
            idx   <= idx + NB'(1);
            state <= S_RLX_A;
          end
        end
        S_TRC_A: begin
          // push the current node, or node 1 to close the path
          depth <= depth + (NB+1)'(1);
          if (cur != '0 && CMPW'(depth) < CMPW'(nlast)) begin
            state <= S_TRC_D;
          end else begin
            state <= S_POP_A;
          end
        end
        S_TRC_D: begin
          cur   <= pred_rd;
          state <= S_TRC_A;
        end
        S_POP_A: begin
          state <= S_POP_D;
        end
        S_POP_D: begin
          depth       <= depth - (NB+1)'(1);
          out_node    <= node_wide[NODE_W-1:0];
          out_no_path <= 1'b0;
          out_last    <= (depth == (NB+1)'(1));
          out_valid   <= 1'b1;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            state     <= out_last ? S_IDLE : S_POP_A;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/spd_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the shortest path block, bound to the top level.
// Depends on spd_pkg and shortest_path_dijkstra_top.
module spd_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [spd_pkg::NODE_W-1:0] res_node,
  input logic                       res_no_path,
  input logic                       res_last
);
  import spd_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  a_no_path: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_no_path |-> res_last && res_node == '0)
    else $error("no_path beat is not a lone last beat");

  a_node_nz: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_no_path |-> res_node != '0)
    else $error("path beat with node 0");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !item_ready)
    else $error("input taken while a path beat waits");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_node))
    else $error("stalled result beat changed");

endmodule

bind shortest_path_dijkstra_top spd_chk u_spd_chk (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_node    (result.path_node),
  .res_no_path (result.no_path),
  .res_last    (result.last)
);

/* tb/shortest_path_dijkstra_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for shortest_path_dijkstra_top: edge, solve and clear
// beats are driven with random idling and path beats checked against a predictor.
// Depends on spd_pkg, spd_if.sv and the block itself.
module shortest_path_dijkstra_top_tb;
  import spd_pkg::*;

  typedef struct {
    cmd_t             cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [WEIGHT_W-1:0] weight;
  } edge_cmd_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic              no_path;
    logic              last;
  } path_beat_t;

  localparam int NODES   = DEF_MAX_NODES;
  localparam longint unsigned DIST_SAT = (64'd1 << DEF_DIST_BITS) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [NODE_W-1:0] cfg_wdata = '0;

  spd_item_if   item_ch ();
  spd_result_if path_ch ();

  shortest_path_dijkstra_top dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (path_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [WEIGHT_W:0] weight_store [NODES][NODES];
  logic [NODE_W-1:0] node_count_reg;
  edge_cmd_t  pending_cmds [$];
  path_beat_t expected_path [$];
  int errors = 0;

  function automatic int active_nodes();
    if (node_count_reg < 1) return 1;
    if (node_count_reg > NODES) return NODES;
    return node_count_reg;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++)
        weight_store[i][j] = '0;
  endfunction

  function automatic void predict_path();
    int n;
    int best;
    int hops;
    int cur;
    path_beat_t beat;
    longint unsigned node_dist [NODES];
    int prev [NODES];
    bit seen [NODES];
    bit done [NODES];
    int trail [NODES];
    longint unsigned cand;
    n = active_nodes();
    for (int i = 0; i < NODES; i++) begin
      node_dist[i] = 0; prev[i] = 0; seen[i] = 0; done[i] = 0;
    end
    seen[0] = 1;
    forever begin
      best = -1;
      for (int i = 0; i < n; i++)
        if (seen[i] && !done[i] && (best < 0 || node_dist[i] < node_dist[best])) best = i;
      if (best < 0) break;
      done[best] = 1;
      for (int u = 0; u < n; u++) begin
        if (done[u] || !weight_store[best][u][WEIGHT_W]) continue;
        cand = node_dist[best] + weight_store[best][u][WEIGHT_W-1:0];
        if (cand > DIST_SAT) cand = DIST_SAT;
        if (!seen[u] || cand < node_dist[u]) begin
          seen[u] = 1; node_dist[u] = cand; prev[u] = best;
        end
      end
    end
    if (!seen[n-1]) begin
      beat.node = '0; beat.no_path = 1'b1; beat.last = 1'b1;
      expected_path = {expected_path, beat};
      return;
    end
    hops = 0;
    cur = n - 1;
    while (cur != 0 && hops < n - 1) begin
      trail[hops] = cur;
      hops = hops + 1;
      cur = prev[cur];
    end
    trail[hops] = 0;
    hops = hops + 1;
    while (hops > 0) begin
      hops--;
      beat.node = NODE_W'(trail[hops] + 1);
      beat.no_path = 1'b0;
      beat.last = (hops == 0);
      expected_path = {expected_path, beat};
    end
  endfunction

  function automatic void apply_cmd(edge_cmd_t c);
    int n;
    int i;
    int j;
    n = active_nodes();
    case (c.cmd)
      CMD_ADD: begin
        if (c.node_a < 1 || c.node_a > n || c.node_b < 1 || c.node_b > n) return;
        i = c.node_a - 1;
        j = c.node_b - 1;
        if (!weight_store[i][j][WEIGHT_W] || c.weight < weight_store[i][j][WEIGHT_W-1:0]) begin
          weight_store[i][j] = {1'b1, c.weight};
          weight_store[j][i] = {1'b1, c.weight};
        end
      end
      CMD_SOLVE: predict_path();
      CMD_CLEAR: clear_store();
      default: ;
    endcase
  endfunction

  // Driver: bursts of random length separated by random gaps
  edge_cmd_t in_flight;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) apply_cmd(in_flight);
      if (item_ch.valid && !item_ch.ready) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        item_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        in_flight = pending_cmds.pop_front();
        item_ch.valid       <= 1'b1;
        item_ch.command     <= in_flight.cmd;
        item_ch.first_node  <= in_flight.node_a;
        item_ch.second_node <= in_flight.node_b;
        item_ch.edge_weight <= in_flight.weight;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: ready pattern by window, plus one long hold-off
  int cycle_cnt = 0;
  int beats_seen = 0;
  int hold_left = 0;
  bit held_once = 0;
  path_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      path_ch.ready <= 1'b0;
    end else begin
      cycle_cnt++;
      if (path_ch.valid && path_ch.ready) begin
        beats_seen++;
        if (expected_path.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat node=%0d no_path=%0b last=%0b", $time,
                   path_ch.path_node, path_ch.no_path, path_ch.last);
        end else begin
          want = expected_path.pop_front();
          if (path_ch.path_node !== want.node || path_ch.no_path !== want.no_path ||
              path_ch.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected node=%0d no_path=%0b last=%0b,",
                     $time, want.node, want.no_path, want.last,
                     " got node=%0d no_path=%0b last=%0b",
                     path_ch.path_node, path_ch.no_path, path_ch.last);
          end
        end
      end
      if (!held_once && beats_seen >= 6 && path_ch.valid) begin
        held_once = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        path_ch.ready <= 1'b0;
      end else begin
        case ((cycle_cnt / 150) % 3)
          0: path_ch.ready <= 1'b1;
          1: path_ch.ready <= ($urandom_range(0, 3) != 0);
          default: path_ch.ready <= ($urandom_range(0, 4) < 2);
        endcase
      end
    end
  end

  function automatic void queue_cmd(cmd_t c, int a, int b, int w);
    edge_cmd_t e;
    e.cmd = c;
    e.node_a = NODE_W'(a);
    e.node_b = NODE_W'(b);
    e.weight = WEIGHT_W'(w);
    pending_cmds = {pending_cmds, e};
  endfunction

  function automatic void queue_random(int n, int count);
    int pick;
    int a;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queue_cmd(CMD_SOLVE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end else if (pick < 15) begin
        queue_cmd(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end else if (pick < 18) begin
        queue_cmd(CMD_NONE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end else if (pick < 26) begin
        queue_cmd(CMD_ADD, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end else if (pick < 55) begin
        // chain-like edges make the target reachable more often
        a = $urandom_range(1, n);
        queue_cmd(CMD_ADD, a, (a < n) ? a + 1 : a, $urandom_range(0, 15));
      end else begin
        queue_cmd(CMD_ADD, $urandom_range(1, n), $urandom_range(1, n),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(0, 31) : $urandom);
      end
    end
    queue_cmd(CMD_SOLVE, 0, 0, 0);
  endfunction

  // Wait until every beat is sent, every result is back and the block is idle
  task automatic drain();
    while (pending_cmds.size() > 0 || item_ch.valid || expected_path.size() > 0 ||
           !item_ch.ready)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_node_count(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= NODE_W'(v);
    node_count_reg = NODE_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int phase_counts [8] = '{5, 3, 8, 2, 64, 12, 6, 100};

  initial begin
    clear_store();
    node_count_reg = NODE_COUNT_RST;
    item_ch.valid = 1'b0;
    item_ch.command = CMD_NONE;
    item_ch.first_node = '0;
    item_ch.second_node = '0;
    item_ch.edge_weight = '0;
    path_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: default node count, extremes, parallel edges, self loop, bad ends
    queue_cmd(CMD_ADD, 1, 64, 20'hFFFFF);
    queue_cmd(CMD_SOLVE, 0, 0, 0);
    queue_cmd(CMD_ADD, 1, 64, 20'hFFFFF);
    queue_cmd(CMD_ADD, 64, 1, 5);
    queue_cmd(CMD_ADD, 1, 64, 9);
    queue_cmd(CMD_ADD, 1, 1, 0);
    queue_cmd(CMD_ADD, 0, 64, 0);
    queue_cmd(CMD_ADD, 127, 1, 0);
    queue_cmd(CMD_ADD, 1, 127, 0);
    queue_cmd(CMD_ADD, 1, 2, 0);
    queue_cmd(CMD_ADD, 2, 64, 5);
    queue_cmd(CMD_NONE, 127, 127, 20'hFFFFF);
    queue_cmd(CMD_SOLVE, 127, 127, 20'hFFFFF);
    queue_cmd(CMD_CLEAR, 0, 0, 0);
    queue_cmd(CMD_SOLVE, 0, 0, 0);
    drain();

    // Single node, then a count of zero acting as one
    write_node_count(1);
    queue_cmd(CMD_ADD, 1, 1, 3);
    queue_cmd(CMD_ADD, 1, 2, 3);
    queue_cmd(CMD_SOLVE, 0, 0, 0);
    drain();
    write_node_count(0);
    queue_cmd(CMD_SOLVE, 0, 0, 0);
    queue_cmd(CMD_CLEAR, 0, 0, 0);
    drain();

    // Random phases over several node counts; each boundary idles the sender
    foreach (phase_counts[p]) begin
      write_node_count(phase_counts[p]);
      queue_random((phase_counts[p] > NODES) ? NODES : phase_counts[p],
                   (phase_counts[p] >= NODES) ? 12 : 20);
      drain();
    end

    if (errors == 0) begin
      $display("shortest_path_dijkstra_top regression: pass");
    end else begin
      $display("shortest_path_dijkstra_top regression: fail");
    end
    $finish;
  end

  initial begin
    #150ms;
    $display("shortest_path_dijkstra_top regression: fail");
    $finish;
  end

endmodule

/* files.f */
sv/spd_pkg.sv
sv/spd_if.sv
sv/shortest_path_dijkstra_top.sv
sv/spd_chk.sv
tb/shortest_path_dijkstra_top_tb.sv
